// ----- design/fcl_pkg.sv -----
package fcl_pkg;

  // default sizes
  localparam int MAX_IN_DEF  = 64;
  localparam int MAX_OUT_DEF = 64;

  // config register widths and indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int DIM_W      = 7;

  localparam logic [CFG_IDX_W-1:0] REG_IN_DIMS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_DIMS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_USE_BIAS = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_ACT    = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  // sequencer to datapath
  typedef struct packed {
    logic take;     // request accepted this cycle
    logic clr;      // sample start: drop all accumulator valid bits
    logic mac_rd;   // issue weight read for one output
    logic emit_rd;  // issue accumulator and bias read for one result
    logic last;     // final result of the sample
  } ctl_t;

endpackage

// ----- design/fcl_ctrl.sv -----
module fcl_ctrl #(
  parameter int MAX_IN  = fcl_pkg::MAX_IN_DEF,
  parameter int MAX_OUT = fcl_pkg::MAX_OUT_DEF,
  localparam int DW = $clog2(MAX_IN + 1),
  localparam int CW = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
  localparam int OW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         func,
  input  logic [DW-1:0]      nin,
  input  logic [OW-1:0]      nout_last,
  output logic               busy,
  output fcl_pkg::ctl_t      ctl,
  output logic [OW-1:0]      idx,
  output logic [CW-1:0]      col
);

  fcl_pkg::state_t state, state_next;
  logic [DW-1:0] count;
  logic          fin;
  logic          drain;
  logic          take;
  logic          take_act;
  logic          at_last;

  assign take     = start && (state == fcl_pkg::ST_IDLE);
  assign take_act = take && (func == fcl_pkg::FUNC_ACT);
  assign at_last  = (idx == nout_last);
  assign col      = CW'(count);

  always_comb begin
    state_next = state;
    case (state)
      fcl_pkg::ST_IDLE: begin
        if (take_act) state_next = fcl_pkg::ST_MAC;
      end
      fcl_pkg::ST_MAC: begin
        if (at_last) state_next = fcl_pkg::ST_DRAIN;
      end
      fcl_pkg::ST_DRAIN: begin
        if (drain) state_next = fin ? fcl_pkg::ST_EMIT : fcl_pkg::ST_IDLE;
      end
      fcl_pkg::ST_EMIT: begin
        if (at_last) state_next = fcl_pkg::ST_IDLE;
      end
      default: state_next = fcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = (state != fcl_pkg::ST_IDLE);
    ctl.take    = take;
    ctl.clr     = take_act && (count == '0);
    ctl.mac_rd  = (state == fcl_pkg::ST_MAC);
    ctl.emit_rd = (state == fcl_pkg::ST_EMIT);
    ctl.last    = (state == fcl_pkg::ST_EMIT) && at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fcl_pkg::ST_IDLE;
      idx   <= '0;
      count <= '0;
      fin   <= 1'b0;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        fcl_pkg::ST_IDLE: begin
          if (take_act) begin
            idx   <= '0;
            drain <= 1'b0;
            fin   <= ((DW+1)'(count) + (DW+1)'(1)) >= (DW+1)'(nin);
          end
        end
        fcl_pkg::ST_MAC: begin
          idx <= at_last ? '0 : idx + OW'(1);
        end
        fcl_pkg::ST_DRAIN: begin
          drain <= 1'b1;
          if (drain) count <= fin ? '0 : count + DW'(1);
        end
        fcl_pkg::ST_EMIT: begin
          idx <= at_last ? '0 : idx + OW'(1);
        end
        default: idx <= '0;
      endcase
    end
  end

  // clear of valid bits only when a sample starts from idle
  a_clr_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.clr |-> (state == fcl_pkg::ST_IDLE) && take_act)
    else $error("valid clear outside sample start");

  // no overlap between request take, mac issue and emit issue
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.take, ctl.mac_rd, ctl.emit_rd}))
    else $error("overlapping datapath operations");

  a_act_start: assert property (@(posedge clk) disable iff (rst)
    take_act |=> (state == fcl_pkg::ST_MAC) && (idx == '0))
    else $error("activation did not start mac sweep at row 0");

  a_drain_len: assert property (@(posedge clk) disable iff (rst)
    (state == fcl_pkg::ST_DRAIN) && drain |=> (state != fcl_pkg::ST_DRAIN))
    else $error("drain longer than two cycles");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.last |=> (state == fcl_pkg::ST_IDLE) && !busy)
    else $error("no return to idle after final result");

endmodule

// ----- design/fcl_datapath.sv -----
module fcl_datapath #(
  parameter int MAX_IN  = fcl_pkg::MAX_IN_DEF,
  parameter int MAX_OUT = fcl_pkg::MAX_OUT_DEF,
  localparam int CW    = (MAX_IN > 1) ? $clog2(MAX_IN) : 1,
  localparam int OW    = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1,
  localparam int WDEP  = MAX_OUT * MAX_IN,
  localparam int AW    = (WDEP > 1) ? $clog2(WDEP) : 1,
  localparam int ACC_W = 33 + $clog2(MAX_IN + 1),
  localparam int SW    = ACC_W + 1
) (
  input  logic               clk,
  input  logic               rst,
  input  fcl_pkg::ctl_t      ctl,
  input  logic [1:0]         func,
  input  logic [5:0]         row_index,
  input  logic [5:0]         col_index,
  input  logic signed [15:0] value,
  input  logic [OW-1:0]      idx,
  input  logic [CW-1:0]      col,
  input  logic               use_bias,
  output logic               strobe,
  output logic [5:0]         out_index,
  output logic signed [31:0] result,
  output logic               last
);

  localparam logic signed [SW-1:0] SAT_HI = SW'(2147483647);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  logic signed [15:0]      wmem [WDEP];
  logic signed [15:0]      bmem [MAX_OUT];
  logic signed [ACC_W-1:0] amem [MAX_OUT];
  logic [MAX_OUT-1:0]      vbits;

  logic signed [15:0]      act;
  logic signed [15:0]      w_q;
  logic signed [15:0]      b_q;
  logic signed [ACC_W-1:0] a_q;
  logic signed [31:0]      prod;

  logic                    v1, v2, ev1;
  logic [OW-1:0]           idx1, idx2, eidx1;
  logic                    elast1;

  logic                    row_ok, col_ok;
  logic [AW-1:0]           waddr, raddr;
  logic [OW-1:0]           aaddr;
  logic                    ard;
  logic signed [ACC_W-1:0] acc_old, acc_new, acc_e;
  logic signed [SW-1:0]    bias_term, sum;

  assign row_ok = int'(row_index) < MAX_OUT;
  assign col_ok = int'(col_index) < MAX_IN;
  assign waddr  = AW'(int'(row_index) * MAX_IN + int'(col_index));
  assign raddr  = AW'(int'(idx) * MAX_IN + int'(col));

  // weight store
  always_ff @(posedge clk) begin
    if (ctl.take && (func == fcl_pkg::FUNC_WEIGHT) && row_ok && col_ok)
      wmem[waddr] <= value;
    if (ctl.mac_rd) w_q <= wmem[raddr];
  end

  // bias store
  always_ff @(posedge clk) begin
    if (ctl.take && (func == fcl_pkg::FUNC_BIAS) && row_ok)
      bmem[OW'(row_index)] <= value;
    if (ctl.emit_rd) b_q <= bmem[idx];
  end

  // accumulator store: read at s1 (mac) or e0 (emit), write at s2
  assign aaddr   = v1 ? idx1 : idx;
  assign ard     = v1 || ctl.emit_rd;
  assign acc_old = vbits[idx2] ? a_q : '0;
  assign acc_new = acc_old + ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (ard) a_q <= amem[aaddr];
    if (v2) amem[idx2] <= acc_new;
  end

  // invalid entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
    end else if (ctl.clr) begin
      vbits <= '0;
    end else if (v2) begin
      vbits[idx2] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take && (func == fcl_pkg::FUNC_ACT)) act <= value;
  end

  // mac pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      ev1 <= 1'b0;
    end else begin
      v1  <= ctl.mac_rd;
      v2  <= v1;
      ev1 <= ctl.emit_rd;
    end
  end

  always_ff @(posedge clk) begin
    idx1   <= idx;
    idx2   <= idx1;
    eidx1  <= idx;
    elast1 <= ctl.last;
    if (v1) prod <= w_q * act;
  end

  // result: sum plus scaled bias, saturated to 32 bits
  assign acc_e     = vbits[eidx1] ? a_q : '0;
  assign bias_term = use_bias ? (SW'(b_q) <<< 8) : '0;
  assign sum       = SW'(acc_e) + bias_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ev1;
    end
  end

  always_ff @(posedge clk) begin
    out_index <= 6'(eidx1);
    last      <= elast1;
    if (sum > SAT_HI) begin
      result <= SAT_HI[31:0];
    end else if (sum < SAT_LO) begin
      result <= SAT_LO[31:0];
    end else begin
      result <= sum[31:0];
    end
  end

endmodule

// ----- design/fully_connected_layer_forward_core.sv -----
// Channel  Signals                                   Direction  Handshake
// -------  ----------------------------------------  ---------  -----------------------------
// config   cfg_we, cfg_index, cfg_data              in         written when cfg_we is high
// request  start, func, row_index, col_index, value in         taken when start && !busy
// busy     busy                                      out        high while a request is worked
// result   strobe, out_index, result, last           out        one result per strobe, no stall
//
// Weight and bias write requests do not raise busy.
// An activation request raises busy while one shared multiplier visits the
// outputs one per cycle, through the weight and accumulator memory ports.
// The final activation of a sample then reads out the results; each one passes the
// ev1 and strobe registers after its read and appears on strobe, one per cycle.
// Reset (rst, synchronous) drops the sequencer to idle, clears the element count and
// the accumulator valid bits; the weight and bias memories keep their contents.
// The receiver of results cannot stall; nothing is ever held back on that side.
module fully_connected_layer_forward_core #(
  parameter int MAX_IN  = fcl_pkg::MAX_IN_DEF,
  parameter int MAX_OUT = fcl_pkg::MAX_OUT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration
  input  logic                             cfg_we,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // request
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func,
  input  logic [5:0]                       row_index,
  input  logic [5:0]                       col_index,
  input  logic signed [15:0]               value,
  // results
  output logic                             strobe,
  output logic [5:0]                       out_index,
  output logic signed [31:0]               result,
  output logic                             last
);

  localparam int DW   = $clog2(MAX_IN + 1);
  localparam int CW   = (MAX_IN > 1) ? $clog2(MAX_IN) : 1;
  localparam int OW   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CMPW = (DW > fcl_pkg::DIM_W) ? DW : fcl_pkg::DIM_W;

  // config registers
  logic [fcl_pkg::DIM_W-1:0] in_dims;
  logic [fcl_pkg::DIM_W-1:0] out_dims;
  logic                      use_bias;

  // clamped dimensions
  logic [CMPW-1:0]           in_ext;
  logic [DW-1:0]             nin;
  logic [fcl_pkg::DIM_W-1:0] nout;
  logic [OW-1:0]             nout_last;

  fcl_pkg::ctl_t             ctl;
  logic [OW-1:0]             idx;
  logic [CW-1:0]             col;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_dims  <= fcl_pkg::DIM_RESET;
      out_dims <= fcl_pkg::DIM_RESET;
      use_bias <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        fcl_pkg::REG_IN_DIMS:  in_dims  <= cfg_data;
        fcl_pkg::REG_OUT_DIMS: out_dims <= cfg_data;
        fcl_pkg::REG_USE_BIAS: use_bias <= cfg_data[0];
        default: ;  // unused index: ignored
      endcase
    end
  end

  // zero acts as one, oversize acts as the maximum
  assign in_ext = CMPW'(in_dims);

  always_comb begin
    if (in_ext == '0) begin
      nin = DW'(1);
    end else if (in_ext > CMPW'(MAX_IN)) begin
      nin = DW'(MAX_IN);
    end else begin
      nin = DW'(in_ext);
    end

    if (out_dims == '0) begin
      nout = fcl_pkg::DIM_W'(1);
    end else if (out_dims > fcl_pkg::DIM_W'(MAX_OUT)) begin
      nout = fcl_pkg::DIM_W'(MAX_OUT);
    end else begin
      nout = out_dims;
    end
  end

  assign nout_last = OW'(nout - fcl_pkg::DIM_W'(1));

  fcl_ctrl #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .func      (func),
    .nin       (nin),
    .nout_last (nout_last),
    .busy      (busy),
    .ctl       (ctl),
    .idx       (idx),
    .col       (col)
  );

  fcl_datapath #(
    .MAX_IN  (MAX_IN),
    .MAX_OUT (MAX_OUT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .func      (func),
    .row_index (row_index),
    .col_index (col_index),
    .value     (value),
    .idx       (idx),
    .col       (col),
    .use_bias  (use_bias),
    .strobe    (strobe),
    .out_index (out_index),
    .result    (result),
    .last      (last)
  );

endmodule
